@@ rtl/clb_pkg.sv @@
// Shared types and codes for the RGBA blend unit.
// Holds factor, operator and register index codes and the control struct.
// No dependencies.
package clb_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [3:0] {
        CF_ZERO               = 4'd0,
        CF_ONE                = 4'd1,
        CF_SRC_COLOR          = 4'd2,
        CF_DST_COLOR          = 4'd3,
        CF_ONE_MINUS_SRC_COLOR = 4'd4,
        CF_ONE_MINUS_DST_COLOR = 4'd5,
        CF_SRC_ALPHA          = 4'd6,
        CF_DST_ALPHA          = 4'd7,
        CF_ONE_MINUS_SRC_ALPHA = 4'd8,
        CF_ONE_MINUS_DST_ALPHA = 4'd9,
        CF_CONST_COLOR        = 4'd10,
        CF_ONE_MINUS_CONST_COLOR = 4'd11,
        CF_CONST_ALPHA        = 4'd12,
        CF_ONE_MINUS_CONST_ALPHA = 4'd13
    } color_factor_t;

    typedef enum logic [2:0] {
        AF_ZERO                = 3'd0,
        AF_ONE                 = 3'd1,
        AF_SRC_ALPHA           = 3'd2,
        AF_DST_ALPHA           = 3'd3,
        AF_ONE_MINUS_SRC_ALPHA = 3'd4,
        AF_ONE_MINUS_DST_ALPHA = 3'd5,
        AF_CONST_ALPHA         = 3'd6,
        AF_ONE_MINUS_CONST_ALPHA = 3'd7
    } alpha_factor_t;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_REV_SUB = 3'd2,
        OP_MIN     = 3'd3,
        OP_MAX     = 3'd4
    } blend_op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SRC_COLOR_FACTOR = 3'd0,
        REG_DST_COLOR_FACTOR = 3'd1,
        REG_COLOR_OPERATOR   = 3'd2,
        REG_SRC_ALPHA_FACTOR = 3'd3,
        REG_DST_ALPHA_FACTOR = 3'd4,
        REG_ALPHA_OPERATOR   = 3'd5,
        REG_CONSTANT_COLOR   = 3'd6,
        REG_CONSTANT_ALPHA   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        color_factor_t src_color_factor;
        color_factor_t dst_color_factor;
        blend_op_t     color_operator;
        alpha_factor_t src_alpha_factor;
        alpha_factor_t dst_alpha_factor;
        blend_op_t     alpha_operator;
    } blend_ctrl_t;

    // map an alpha factor onto the color factor that picks the same value
    function automatic color_factor_t alpha_to_color_factor(alpha_factor_t code);
        color_factor_t res;
        unique case (code)
            AF_ZERO:                  res = CF_ZERO;
            AF_ONE:                   res = CF_ONE;
            AF_SRC_ALPHA:             res = CF_SRC_ALPHA;
            AF_DST_ALPHA:             res = CF_DST_ALPHA;
            AF_ONE_MINUS_SRC_ALPHA:   res = CF_ONE_MINUS_SRC_ALPHA;
            AF_ONE_MINUS_DST_ALPHA:   res = CF_ONE_MINUS_DST_ALPHA;
            AF_CONST_ALPHA:           res = CF_CONST_ALPHA;
            AF_ONE_MINUS_CONST_ALPHA: res = CF_ONE_MINUS_CONST_ALPHA;
            default:                  res = CF_ZERO;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/color_alpha_blend_unit.sv @@
// RGBA blend unit top level: input register, four blend lanes, result register.
// Accepted input passes the input register, then the result register (out_valid); one item
// per cycle unless stalled. A stalled result holds a full input register and stalls input.
// The combinational lane path (one multiply, fold-add, combine) sets the clock rate.
// Reset clears the pipeline valid bits and loads the default blend state
// (source factor one, destination factor zero, add); payload registers are not reset.
// Depends on clb_pkg, clb_cfg, clb_lane and clb_nmul.
module color_alpha_blend_unit
    import clb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [3*CHANNEL_BITS-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [CHANNEL_BITS-1:0]     src_red,
    input  logic [CHANNEL_BITS-1:0]     src_green,
    input  logic [CHANNEL_BITS-1:0]     src_blue,
    input  logic [CHANNEL_BITS-1:0]     src_alpha,
    input  logic [CHANNEL_BITS-1:0]     dst_red,
    input  logic [CHANNEL_BITS-1:0]     dst_green,
    input  logic [CHANNEL_BITS-1:0]     dst_blue,
    input  logic [CHANNEL_BITS-1:0]     dst_alpha,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [CHANNEL_BITS-1:0]     out_red,
    output logic [CHANNEL_BITS-1:0]     out_green,
    output logic [CHANNEL_BITS-1:0]     out_blue,
    output logic [CHANNEL_BITS-1:0]     out_alpha
);

    localparam int LANES = 4;

    blend_ctrl_t                    ctrl;
    logic [3*CHANNEL_BITS-1:0]      constant_color;
    logic [CHANNEL_BITS-1:0]        constant_alpha;

    logic                           in_valid_reg;
    logic [CHANNEL_BITS-1:0]        src_reg [LANES];
    logic [CHANNEL_BITS-1:0]        dst_reg [LANES];
    logic                           out_valid_reg;
    logic [CHANNEL_BITS-1:0]        res_reg [LANES];
    logic [CHANNEL_BITS-1:0]        res_next [LANES];
    logic [CHANNEL_BITS-1:0]        k_chan [LANES];
    color_factor_t                  src_fac [LANES];
    color_factor_t                  dst_fac [LANES];
    blend_op_t                      lane_op [LANES];
    logic                           out_load;
    logic                           in_load;

    clb_cfg #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ctrl           (ctrl),
        .constant_color (constant_color),
        .constant_alpha (constant_alpha)
    );

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load || out_load)
            begin
                in_valid_reg <= in_load;
            end
            if (out_load || !out_stall)
            begin
                out_valid_reg <= out_load;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            src_reg[0] <= src_red;
            src_reg[1] <= src_green;
            src_reg[2] <= src_blue;
            src_reg[3] <= src_alpha;
            dst_reg[0] <= dst_red;
            dst_reg[1] <= dst_green;
            dst_reg[2] <= dst_blue;
            dst_reg[3] <= dst_alpha;
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign k_chan[0]  = constant_color[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign k_chan[1]  = constant_color[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign k_chan[2]  = constant_color[CHANNEL_BITS-1:0];
    assign k_chan[3]  = constant_alpha;

    assign src_fac[0] = ctrl.src_color_factor;
    assign src_fac[1] = ctrl.src_color_factor;
    assign src_fac[2] = ctrl.src_color_factor;
    assign src_fac[3] = alpha_to_color_factor(ctrl.src_alpha_factor);
    assign dst_fac[0] = ctrl.dst_color_factor;
    assign dst_fac[1] = ctrl.dst_color_factor;
    assign dst_fac[2] = ctrl.dst_color_factor;
    assign dst_fac[3] = alpha_to_color_factor(ctrl.dst_alpha_factor);
    assign lane_op[0] = ctrl.color_operator;
    assign lane_op[1] = ctrl.color_operator;
    assign lane_op[2] = ctrl.color_operator;
    assign lane_op[3] = ctrl.alpha_operator;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        clb_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .s_chan     (src_reg[i]),
            .d_chan     (dst_reg[i]),
            .s_alpha    (src_reg[LANES-1]),
            .d_alpha    (dst_reg[LANES-1]),
            .k_chan     (k_chan[i]),
            .k_alpha    (constant_alpha),
            .src_factor (src_fac[i]),
            .dst_factor (dst_fac[i]),
            .op         (lane_op[i]),
            .result     (res_next[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_red   = res_reg[0];
    assign out_green = res_reg[1];
    assign out_blue  = res_reg[2];
    assign out_alpha = res_reg[3];

endmodule

@@ rtl/clb_cfg.sv @@
// Configuration registers of the RGBA blend unit.
// Depends on clb_pkg for codes and the control struct.
module clb_cfg
    import clb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [3*CHANNEL_BITS-1:0]   cfg_data,
    output blend_ctrl_t                 ctrl,
    output logic [3*CHANNEL_BITS-1:0]   constant_color,
    output logic [CHANNEL_BITS-1:0]     constant_alpha
);

    blend_ctrl_t                      ctrl_reg;
    logic [3*CHANNEL_BITS-1:0]        const_color_reg;
    logic [CHANNEL_BITS-1:0]          const_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.src_color_factor <= CF_ONE;
            ctrl_reg.dst_color_factor <= CF_ZERO;
            ctrl_reg.color_operator   <= OP_ADD;
            ctrl_reg.src_alpha_factor <= AF_ONE;
            ctrl_reg.dst_alpha_factor <= AF_ZERO;
            ctrl_reg.alpha_operator   <= OP_ADD;
            const_color_reg           <= '0;
            const_alpha_reg           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SRC_COLOR_FACTOR:
                    ctrl_reg.src_color_factor <= color_factor_t'(cfg_data[3:0]);
                REG_DST_COLOR_FACTOR:
                    ctrl_reg.dst_color_factor <= color_factor_t'(cfg_data[3:0]);
                REG_COLOR_OPERATOR:
                    ctrl_reg.color_operator <= blend_op_t'(cfg_data[2:0]);
                REG_SRC_ALPHA_FACTOR:
                    ctrl_reg.src_alpha_factor <= alpha_factor_t'(cfg_data[2:0]);
                REG_DST_ALPHA_FACTOR:
                    ctrl_reg.dst_alpha_factor <= alpha_factor_t'(cfg_data[2:0]);
                REG_ALPHA_OPERATOR:
                    ctrl_reg.alpha_operator <= blend_op_t'(cfg_data[2:0]);
                REG_CONSTANT_COLOR:
                    const_color_reg <= cfg_data;
                REG_CONSTANT_ALPHA:
                    const_alpha_reg <= cfg_data[CHANNEL_BITS-1:0];
                default:
                    const_alpha_reg <= const_alpha_reg;
            endcase
        end
    end

    assign ctrl           = ctrl_reg;
    assign constant_color = const_color_reg;
    assign constant_alpha = const_alpha_reg;

endmodule

@@ rtl/clb_nmul.sv @@
// Normalized multiply: round(a*b / M) with M = 2^N - 1.
// Division by M done as (x + (x >> N) + 1) >> N. No package dependency.
module clb_nmul #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [CHANNEL_BITS-1:0] a,
    input  logic [CHANNEL_BITS-1:0] b,
    output logic [CHANNEL_BITS-1:0] p
);

    localparam logic [2*CHANNEL_BITS-1:0] HALF = (2*CHANNEL_BITS)'((1 << (CHANNEL_BITS-1)) - 1);

    logic [2*CHANNEL_BITS-1:0] prod;
    logic [2*CHANNEL_BITS-1:0] biased;
    logic [2*CHANNEL_BITS:0]   folded;

    always_comb
    begin
        prod   = {{CHANNEL_BITS{1'b0}}, a} * {{CHANNEL_BITS{1'b0}}, b};
        biased = prod + HALF;
        folded = {1'b0, biased}
               + {{(CHANNEL_BITS+1){1'b0}}, biased[2*CHANNEL_BITS-1:CHANNEL_BITS]}
               + {{(2*CHANNEL_BITS){1'b0}}, 1'b1};
        p      = folded[2*CHANNEL_BITS-1:CHANNEL_BITS];
    end

endmodule

@@ rtl/clb_lane.sv @@
// One blend lane: factor select, two normalized products, combine and clamp.
// Depends on clb_pkg and clb_nmul.
module clb_lane
    import clb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [CHANNEL_BITS-1:0] s_chan,
    input  logic [CHANNEL_BITS-1:0] d_chan,
    input  logic [CHANNEL_BITS-1:0] s_alpha,
    input  logic [CHANNEL_BITS-1:0] d_alpha,
    input  logic [CHANNEL_BITS-1:0] k_chan,
    input  logic [CHANNEL_BITS-1:0] k_alpha,
    input  color_factor_t           src_factor,
    input  color_factor_t           dst_factor,
    input  blend_op_t               op,
    output logic [CHANNEL_BITS-1:0] result
);

    localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

    logic [CHANNEL_BITS-1:0] src_weight;
    logic [CHANNEL_BITS-1:0] dst_weight;
    logic [CHANNEL_BITS-1:0] src_term;
    logic [CHANNEL_BITS-1:0] dst_term;
    logic [CHANNEL_BITS:0]   sum;

    function automatic logic [CHANNEL_BITS-1:0] pick(
        color_factor_t           code,
        logic [CHANNEL_BITS-1:0] sc,
        logic [CHANNEL_BITS-1:0] dc,
        logic [CHANNEL_BITS-1:0] sa,
        logic [CHANNEL_BITS-1:0] da,
        logic [CHANNEL_BITS-1:0] kc,
        logic [CHANNEL_BITS-1:0] ka
    );
        logic [CHANNEL_BITS-1:0] res;
        unique case (code)
            CF_ONE:                   res = CH_MAX;
            CF_SRC_COLOR:             res = sc;
            CF_DST_COLOR:             res = dc;
            CF_ONE_MINUS_SRC_COLOR:   res = CH_MAX - sc;
            CF_ONE_MINUS_DST_COLOR:   res = CH_MAX - dc;
            CF_SRC_ALPHA:             res = sa;
            CF_DST_ALPHA:             res = da;
            CF_ONE_MINUS_SRC_ALPHA:   res = CH_MAX - sa;
            CF_ONE_MINUS_DST_ALPHA:   res = CH_MAX - da;
            CF_CONST_COLOR:           res = kc;
            CF_ONE_MINUS_CONST_COLOR: res = CH_MAX - kc;
            CF_CONST_ALPHA:           res = ka;
            CF_ONE_MINUS_CONST_ALPHA: res = CH_MAX - ka;
            default:                  res = '0;
        endcase
        return res;
    endfunction

    assign src_weight = pick(src_factor, s_chan, d_chan, s_alpha, d_alpha, k_chan, k_alpha);
    assign dst_weight = pick(dst_factor, s_chan, d_chan, s_alpha, d_alpha, k_chan, k_alpha);

    clb_nmul #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_src_mul (
        .a (s_chan),
        .b (src_weight),
        .p (src_term)
    );

    clb_nmul #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dst_mul (
        .a (d_chan),
        .b (dst_weight),
        .p (dst_term)
    );

    always_comb
    begin
        sum = {1'b0, src_term} + {1'b0, dst_term};
        case (op)
            OP_ADD:     result = sum[CHANNEL_BITS] ? CH_MAX : sum[CHANNEL_BITS-1:0];
            OP_SUB:     result = (src_term > dst_term) ? src_term - dst_term : '0;
            OP_REV_SUB: result = (dst_term > src_term) ? dst_term - src_term : '0;
            OP_MIN:     result = (src_term < dst_term) ? src_term : dst_term;
            OP_MAX:     result = (src_term > dst_term) ? src_term : dst_term;
            default:    result = '0;
        endcase
    end

endmodule
